FILE: src/sbt_pkg.sv
// ----------------------------------------------------------------------------
// sbt_pkg
// Shared types and constants for the software timer bank.
// ----------------------------------------------------------------------------
package sbt_pkg;

  localparam int SLOTS_DEF = 8;
  localparam int PERIOD_W  = 16;
  localparam int REM_W     = PERIOD_W + 1;
  localparam int RES_W     = 16;

  typedef logic [2:0] cmd_t;
  localparam cmd_t CMD_TICK     = 3'd0;
  localparam cmd_t CMD_START    = 3'd1;
  localparam cmd_t CMD_STOP     = 3'd2;
  localparam cmd_t CMD_DISPATCH = 3'd3;
  localparam cmd_t CMD_INIT     = 3'd4;
  localparam cmd_t CMD_DEINIT   = 3'd5;

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_PERIODIC = 2'd0;
  localparam kind_t KIND_ONESHOT  = 2'd1;

  typedef logic [1:0] stat_code_t;
  localparam stat_code_t ST_OK       = 2'd0;
  localparam stat_code_t ST_INVALID  = 2'd1;
  localparam stat_code_t ST_NO_SLOT  = 2'd2;
  localparam stat_code_t ST_NOT_INIT = 2'd3;

  localparam logic signed [REM_W-1:0] REM_MIN = {1'b1, {PERIOD_W{1'b0}}};

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_WALK,
    S_DIV,
    S_ALLOC,
    S_DONE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic       load;
    logic       clr_table;
    logic       set_ready;
    logic       set_tick;
    logic       clr_tick;
    logic       status_we;
    stat_code_t status_code;
    logic       walk_step;
    logic       walk_dispatch;
    logic       div_start;
    logic       alloc;
    logic       stop_free;
    logic       out_load;
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    cmd_t cmd;
    logic unit_ready;
    logic ticking;
    logic has_free;
    logic start_ok;
    logic stop_ok;
    logic idx_last;
    logic div_busy;
    logic out_free;
  } ctl_sts_t;

endpackage

FILE: src/sbt_div.sv
// ----------------------------------------------------------------------------
// sbt_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sbt_div import sbt_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [PERIOD_W-1:0] dividend,
  input  logic [RES_W-1:0]    divisor,
  output logic                busy,
  output logic [PERIOD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(PERIOD_W);

  logic                busy_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [RES_W-1:0]    rem_r;
  logic [PERIOD_W-1:0] quo_r;
  logic [RES_W-1:0]    dvs_r;

  logic [RES_W:0] shifted;
  logic [RES_W:0] diff;
  logic           ge;

  assign shifted = {rem_r, quo_r[PERIOD_W-1]};
  assign ge      = shifted >= {1'b0, dvs_r};
  assign diff    = shifted - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == CNT_W'(PERIOD_W - 1)) busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? diff[RES_W-1:0] : shifted[RES_W-1:0];
      quo_r <= {quo_r[PERIOD_W-2:0], ge};
    end
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule

FILE: src/sbt_dp.sv
// ----------------------------------------------------------------------------
// sbt_dp
// Channel table, walk index, divider, result and output registers.
// ----------------------------------------------------------------------------
module sbt_dp import sbt_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  ctl_cmd_t       cmd,
  output ctl_sts_t       sts,
  input  logic [23:0]    in_tdata,
  input  logic [4:0]     in_tuser,
  input  logic           cfg_wr_en,
  input  logic [RES_W-1:0] cfg_wr_data,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [15:0]    out_tdata,
  output logic [1:0]     out_tuser
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);

  // latched item
  cmd_t                cmd_r;
  logic [2:0]          slot_r;
  kind_t               kind_r;
  logic [PERIOD_W-1:0] period_r;

  // channel table
  logic [SLOTS-1:0]                 active_r;
  logic [SLOTS-1:0]                 oneshot_r;
  logic [PERIOD_W-1:0]              period_tab_r [SLOTS];
  logic signed [REM_W-1:0]          rem_r        [SLOTS];
  logic [CNT_W-1:0]                 count_r;
  logic                             ready_r;
  logic                             ticking_r;
  logic [RES_W-1:0]                 res_r;

  // walk and result
  logic [IDX_W-1:0]    idx_r;
  stat_code_t          status_r;
  logic [IDX_W-1:0]    assigned_r;
  logic [SLOTS-1:0]    fired_r;

  // output stage
  logic                out_valid_r;
  stat_code_t          out_status_r;
  logic [2:0]          out_assigned_r;
  logic [7:0]          out_fired_r;
  logic [3:0]          out_count_r;

  logic [IDX_W-1:0]    free_idx;
  logic                has_free;
  logic [IDX_W+2:0]    slot_wide;
  logic [IDX_W-1:0]    slot_idx;
  logic                slot_in_range;
  logic                cur_act;
  logic signed [REM_W-1:0] cur_rem;
  logic                fire;
  logic                free_one;
  logic [RES_W-1:0]    divisor;
  logic                div_busy;
  logic [PERIOD_W-1:0] quotient;
  logic [IDX_W+2:0]    assigned_wide;
  logic [SLOTS+7:0]    fired_wide;
  logic [CNT_W+3:0]    count_wide;
  logic [CNT_W-1:0]    count_nxt;

  // lowest free channel
  always_comb begin
    free_idx = '0;
    has_free = 1'b0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!active_r[i]) begin
        free_idx = IDX_W'(i);
        has_free = 1'b1;
      end
    end
  end

  assign slot_wide     = {{IDX_W{1'b0}}, slot_r};
  assign slot_idx      = slot_wide[IDX_W-1:0];
  assign slot_in_range = slot_wide < (IDX_W + 3)'(SLOTS);

  assign cur_act  = active_r[idx_r];
  assign cur_rem  = rem_r[idx_r];
  assign fire     = cmd.walk_step && cmd.walk_dispatch && cur_act &&
                    (cur_rem <= 0);
  assign free_one = fire && oneshot_r[idx_r];

  assign divisor = (res_r == '0) ? RES_W'(1) : res_r;

  sbt_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (period_r),
    .divisor  (divisor),
    .busy     (div_busy),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r    <= in_tuser[2:0];
      kind_r   <= in_tuser[4:3];
      slot_r   <= in_tdata[2:0];
      period_r <= in_tdata[18:3];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r <= RES_W'(1);
    end else if (cfg_wr_en) begin
      res_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ready_r   <= 1'b0;
      ticking_r <= 1'b0;
    end else begin
      if (cmd.set_ready) ready_r <= 1'b1;
      if (cmd.set_tick)  ticking_r <= 1'b1;
      if (cmd.clr_tick)  ticking_r <= 1'b0;
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.clr_table) begin
      count_nxt = '0;
    end else if (cmd.alloc) begin
      count_nxt = count_r + 1'b1;
    end else if (cmd.stop_free || free_one) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (cmd.clr_table) begin
        active_r <= '0;
      end else if (cmd.alloc) begin
        active_r[free_idx] <= 1'b1;
      end else if (cmd.stop_free) begin
        active_r[slot_idx] <= 1'b0;
      end else if (free_one) begin
        active_r[idx_r] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.alloc) begin
      oneshot_r[free_idx]    <= (kind_r == KIND_ONESHOT);
      period_tab_r[free_idx] <= quotient;
      rem_r[free_idx]        <= signed'({1'b0, quotient});
    end else if (cmd.walk_step && cur_act) begin
      if (cmd.walk_dispatch) begin
        if (fire) rem_r[idx_r] <= cur_rem + signed'({1'b0, period_tab_r[idx_r]});
      end else if (cur_rem != REM_MIN) begin
        rem_r[idx_r] <= cur_rem - REM_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      idx_r      <= '0;
      status_r   <= ST_OK;
      assigned_r <= '0;
      fired_r    <= '0;
    end else begin
      if (cmd.walk_step) idx_r <= idx_r + 1'b1;
      if (cmd.status_we) status_r <= cmd.status_code;
      if (cmd.alloc)     assigned_r <= free_idx;
      if (fire)          fired_r[idx_r] <= 1'b1;
    end
  end

  assign assigned_wide = {3'b000, assigned_r};
  assign fired_wide    = {8'h00, fired_r};
  assign count_wide    = {4'h0, count_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r   <= status_r;
      out_assigned_r <= assigned_wide[2:0];
      out_fired_r    <= fired_wide[7:0];
      out_count_r    <= count_wide[3:0];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {1'b0, out_count_r, out_fired_r, out_assigned_r};

  always_comb begin
    sts            = '0;
    sts.cmd        = cmd_r;
    sts.unit_ready = ready_r;
    sts.ticking    = ticking_r;
    sts.has_free   = has_free;
    sts.start_ok   = (kind_r == KIND_PERIODIC || kind_r == KIND_ONESHOT) &&
                     (period_r != '0);
    sts.stop_ok    = slot_in_range && active_r[slot_idx];
    sts.idx_last   = idx_r == IDX_W'(SLOTS - 1);
    sts.div_busy   = div_busy;
    sts.out_free   = !out_valid_r || out_tready;
  end

`ifndef SYNTHESIS
  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    int'(count_r) == $countones(active_r))
    else $error("running count out of step with active channels");

  a_tick_needs_ready: assert property (@(posedge clk) disable iff (!rst_n)
    ticking_r |-> ready_r)
    else $error("ticking while unit not ready");

  a_alloc_has_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.alloc |-> has_free)
    else $error("allocation into a full table");
`endif

endmodule

FILE: src/sbt_ctrl.sv
// ----------------------------------------------------------------------------
// sbt_ctrl
// Command sequencer: decode, channel walk, divide, allocate, hand off result.
// ----------------------------------------------------------------------------
module sbt_ctrl import sbt_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  input  ctl_sts_t sts,
  output ctl_cmd_t cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_DONE;
        unique case (sts.cmd)
          CMD_TICK: begin
            if (!sts.ticking) begin
              cmd.status_we   = 1'b1;
              cmd.status_code = ST_NOT_INIT;
            end else begin
              state_nxt = S_WALK;
            end
          end
          CMD_START: begin
            if (!sts.unit_ready) begin
              cmd.status_we   = 1'b1;
              cmd.status_code = ST_NOT_INIT;
            end else if (!sts.has_free) begin
              cmd.status_we   = 1'b1;
              cmd.status_code = ST_NO_SLOT;
            end else if (!sts.start_ok) begin
              cmd.status_we   = 1'b1;
              cmd.status_code = ST_INVALID;
            end else begin
              cmd.div_start = 1'b1;
              state_nxt     = S_DIV;
            end
          end
          CMD_STOP: begin
            if (sts.stop_ok) begin
              cmd.stop_free = 1'b1;
            end else begin
              cmd.status_we   = 1'b1;
              cmd.status_code = ST_INVALID;
            end
          end
          CMD_DISPATCH: begin
            if (!sts.unit_ready) begin
              cmd.status_we   = 1'b1;
              cmd.status_code = ST_NOT_INIT;
            end else begin
              state_nxt = S_WALK;
            end
          end
          CMD_INIT: begin
            cmd.clr_table = 1'b1;
            cmd.set_ready = 1'b1;
            cmd.set_tick  = 1'b1;
          end
          CMD_DEINIT: begin
            cmd.clr_table = 1'b1;
            cmd.clr_tick  = 1'b1;
          end
          default: begin
            cmd.status_we   = 1'b1;
            cmd.status_code = ST_INVALID;
          end
        endcase
      end
      S_WALK: begin
        cmd.walk_step     = 1'b1;
        cmd.walk_dispatch = (sts.cmd == CMD_DISPATCH);
        if (sts.idx_last) state_nxt = S_DONE;
      end
      S_DIV: begin
        if (!sts.div_busy) state_nxt = S_ALLOC;
      end
      S_ALLOC: begin
        cmd.alloc = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

FILE: src/software_timer_bank_top.sv
// ----------------------------------------------------------------------------
// software_timer_bank_top
// Bank of timer channels driven by one command per beat, one result per beat.
//
//   channel  direction  tdata (low bit up)                tuser (low bit up)
//   in_      slave      slot[2:0] period_ms[18:3]         cmd[2:0] timer_kind[4:3]
//   out_     master     slot_assigned[2:0] fired_mask     status[1:0]
//                       [10:3] active_count[14:11]
//   cfg_     write      tick_resolution[15:0]             -
//
// Stop, init, deinit and rejected commands go from decode straight to the result.
// Tick and dispatch walk every channel in turn, one channel visited per cycle.
// Start waits on the one-bit-per-cycle 16-bit divider, then allocates a channel.
// One command in flight; a finished result waits in the output register
// while the next beat is accepted. Reset is synchronous; table clears at once.
// ----------------------------------------------------------------------------
module software_timer_bank_top import sbt_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [23:0]      in_tdata,   // slot, period_ms, zero pad
  input  logic [4:0]       in_tuser,   // cmd, timer_kind
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [15:0]      out_tdata,  // slot_assigned, fired_mask, active_count
  output logic [1:0]       out_tuser,  // status
  input  logic             cfg_wr_en,
  input  logic [RES_W-1:0] cfg_wr_data // tick_resolution
);

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  sbt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  sbt_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

endmodule
